### rtl/core/adaptive_interval_controller_assert.svh
// Assertion macros for the adaptive interval controller.
// Included by the top level; depends on nothing else.
`ifndef ADAPTIVE_INTERVAL_CONTROLLER_ASSERT_SVH
`define ADAPTIVE_INTERVAL_CONTROLLER_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define AIC_CHECK(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks a consequence in the cycle after the antecedent holds.
`define AIC_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/aic_pkg.sv
// Shared types and constants for the adaptive interval controller.
// Used by aic_datapath and adaptive_interval_controller; depends on nothing.
package aic_pkg;

    localparam int unsigned THR_W    = 16;
    localparam int unsigned FACTOR_W = 16;
    localparam int unsigned CFG_IV_W = 24;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ACT_W    = 16;
    // Fraction bits of the Q8.8 factors.
    localparam int unsigned FRAC_W   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_THRESHOLD = 3'd0,
        REG_LOW_THRESHOLD  = 3'd1,
        REG_SHRINK_FACTOR  = 3'd2,
        REG_GROW_FACTOR    = 3'd3,
        REG_MIN_INTERVAL   = 3'd4,
        REG_MAX_INTERVAL   = 3'd5,
        REG_START_INTERVAL = 3'd6
    } cfg_index_t;

    localparam logic OP_RECORD  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [THR_W-1:0]    HIGH_THRESHOLD_RST = 16'd205;
    localparam logic [THR_W-1:0]    LOW_THRESHOLD_RST  = 16'd51;
    localparam logic [FACTOR_W-1:0] SHRINK_FACTOR_RST  = 16'd128;
    localparam logic [FACTOR_W-1:0] GROW_FACTOR_RST    = 16'd512;
    localparam logic [CFG_IV_W-1:0] MIN_INTERVAL_RST   = 24'd10;
    localparam logic [CFG_IV_W-1:0] MAX_INTERVAL_RST   = 24'd10000;
    localparam logic [CFG_IV_W-1:0] START_INTERVAL_RST = 24'd1000;

    typedef struct packed {
        logic [THR_W-1:0]    high_threshold;
        logic [THR_W-1:0]    low_threshold;
        logic [FACTOR_W-1:0] shrink_factor;
        logic [FACTOR_W-1:0] grow_factor;
        logic [CFG_IV_W-1:0] min_interval;
        logic [CFG_IV_W-1:0] max_interval;
        logic [CFG_IV_W-1:0] start_interval;
    } cfg_t;

    typedef struct packed {
        logic changed;
        logic at_min;
        logic at_max;
    } flags_t;

endpackage

### rtl/core/aic_datapath.sv
// Next-state logic for one item: threshold test, Q8.8 scale with round half up,
// clamp, status flags and saturating counters. Depends on aic_pkg.
module aic_datapath #(
    parameter int unsigned INTERVAL_BITS = 24,
    parameter int unsigned COUNT_BITS    = 32
) (
    input  logic                         op,
    input  logic [aic_pkg::ACT_W-1:0]    activity,
    input  aic_pkg::cfg_t                cfg,
    input  logic [INTERVAL_BITS-1:0]     interval,
    input  logic [COUNT_BITS-1:0]        records,
    input  logic [COUNT_BITS-1:0]        speedups,
    input  logic [COUNT_BITS-1:0]        slowdowns,
    output logic [INTERVAL_BITS-1:0]     interval_next,
    output aic_pkg::flags_t              flags,
    output logic [COUNT_BITS-1:0]        records_next,
    output logic [COUNT_BITS-1:0]        speedups_next,
    output logic [COUNT_BITS-1:0]        slowdowns_next
);

    localparam int unsigned PROD_W = INTERVAL_BITS + aic_pkg::FACTOR_W;
    localparam int unsigned SCALE_W = PROD_W - aic_pkg::FRAC_W;
    localparam int unsigned CMP_W =
        (SCALE_W > aic_pkg::CFG_IV_W) ? SCALE_W : aic_pkg::CFG_IV_W;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (aic_pkg::FRAC_W - 1);

    logic                      is_record;
    logic                      hit_high;
    logic                      hit_low;
    logic [aic_pkg::FACTOR_W-1:0] factor;
    logic [PROD_W-1:0]         product;
    logic [PROD_W-1:0]         rounded;
    logic [CMP_W-1:0]          candidate;
    logic [CMP_W-1:0]          min_ext;
    logic [CMP_W-1:0]          max_ext;
    logic [CMP_W-1:0]          clamped;
    logic [CMP_W-1:0]          next_ext;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    assign is_record = (op == aic_pkg::OP_RECORD);
    assign hit_high  = (activity >= cfg.high_threshold);
    // The high threshold wins when a sample meets both.
    assign hit_low   = !hit_high && (activity <= cfg.low_threshold);
    assign factor    = hit_high ? cfg.shrink_factor : cfg.grow_factor;
    assign product   = PROD_W'(interval) * PROD_W'(factor);
    assign rounded   = product + HALF;

    assign min_ext = CMP_W'(cfg.min_interval);
    assign max_ext = CMP_W'(cfg.max_interval);

    always_comb
    begin
        if (hit_high || hit_low)
        begin
            candidate = CMP_W'(rounded[PROD_W-1:aic_pkg::FRAC_W]);
        end
        else
        begin
            candidate = CMP_W'(interval);
        end
        // Max first, then min, so an inverted range settles on the minimum.
        clamped = (candidate > max_ext) ? max_ext : candidate;
        if (clamped < min_ext)
        begin
            clamped = min_ext;
        end
        if (is_record)
        begin
            interval_next = clamped[INTERVAL_BITS-1:0];
        end
        else
        begin
            interval_next = INTERVAL_BITS'(cfg.start_interval);
        end
    end

    assign next_ext = CMP_W'(interval_next);

    assign flags.changed = is_record && (interval_next != interval);
    assign flags.at_min  = (next_ext <= min_ext);
    assign flags.at_max  = (next_ext >= max_ext);

    assign records_next   = is_record ? sat_inc(records) : records;
    assign speedups_next  = (is_record && hit_high) ? sat_inc(speedups) : speedups;
    assign slowdowns_next = (is_record && hit_low) ? sat_inc(slowdowns) : slowdowns;

endmodule

### rtl/core/adaptive_interval_controller.sv
// Channel  | Dir | Transaction
// s_axis   | in  | tuser: operation; tdata: activity (Q8.8)
// m_axis   | out | tdata: interval, flags, three counters
// cfg      | in  | one register write per cycle with cfg_write high
//
// Each item passes an input register, the next-state logic (a multiply by the
// Q8.8 factor, round and clamp) and a result register, one item per cycle
// sustained while the result is not stalled. The interval feedback loop
// through the multiplier closes combinationally. Reset clears the valid
// bits and counters and loads the start interval. A stalled result holds the
// result register and the pipeline; the input register still takes one item.
// Top level of the adaptive interval controller; depends on aic_pkg,
// aic_datapath and adaptive_interval_controller_assert.svh.
`include "adaptive_interval_controller_assert.svh"

module adaptive_interval_controller #(
    parameter int unsigned INTERVAL_BITS = 24,
    parameter int unsigned COUNT_BITS    = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [aic_pkg::ACT_W-1:0]       s_tdata,   // [15:0] activity
    input  logic                            s_tuser,   // [0] operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // interval_now, changed, at_min, at_max, record_count, speedup_count,
    // slowdown_count, then zero fill to whole bytes
    output logic [((INTERVAL_BITS + 3 + 3*COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                            cfg_write,
    input  logic [aic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aic_pkg::CFG_W-1:0]       cfg_data
);

    localparam int unsigned OUT_W = ((INTERVAL_BITS + 3 + 3*COUNT_BITS + 7) / 8) * 8;

    aic_pkg::cfg_t cfg_reg;

    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic [aic_pkg::ACT_W-1:0]     in_act_reg;

    logic [INTERVAL_BITS-1:0]      interval_reg;
    logic [COUNT_BITS-1:0]         records_reg;
    logic [COUNT_BITS-1:0]         speedups_reg;
    logic [COUNT_BITS-1:0]         slowdowns_reg;

    logic                          out_valid_reg;
    aic_pkg::flags_t               out_flags_reg;

    logic [INTERVAL_BITS-1:0]      interval_next;
    logic [COUNT_BITS-1:0]         records_next;
    logic [COUNT_BITS-1:0]         speedups_next;
    logic [COUNT_BITS-1:0]         slowdowns_next;
    aic_pkg::flags_t               flags_next;

    logic                          advance;

    // The item in the input register moves on when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold <= aic_pkg::HIGH_THRESHOLD_RST;
            cfg_reg.low_threshold  <= aic_pkg::LOW_THRESHOLD_RST;
            cfg_reg.shrink_factor  <= aic_pkg::SHRINK_FACTOR_RST;
            cfg_reg.grow_factor    <= aic_pkg::GROW_FACTOR_RST;
            cfg_reg.min_interval   <= aic_pkg::MIN_INTERVAL_RST;
            cfg_reg.max_interval   <= aic_pkg::MAX_INTERVAL_RST;
            cfg_reg.start_interval <= aic_pkg::START_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                aic_pkg::REG_HIGH_THRESHOLD:
                    cfg_reg.high_threshold <= cfg_data[aic_pkg::THR_W-1:0];
                aic_pkg::REG_LOW_THRESHOLD:
                    cfg_reg.low_threshold <= cfg_data[aic_pkg::THR_W-1:0];
                aic_pkg::REG_SHRINK_FACTOR:
                    cfg_reg.shrink_factor <= cfg_data[aic_pkg::FACTOR_W-1:0];
                aic_pkg::REG_GROW_FACTOR:
                    cfg_reg.grow_factor <= cfg_data[aic_pkg::FACTOR_W-1:0];
                aic_pkg::REG_MIN_INTERVAL:
                    cfg_reg.min_interval <= cfg_data[aic_pkg::CFG_IV_W-1:0];
                aic_pkg::REG_MAX_INTERVAL:
                    cfg_reg.max_interval <= cfg_data[aic_pkg::CFG_IV_W-1:0];
                aic_pkg::REG_START_INTERVAL:
                    cfg_reg.start_interval <= cfg_data[aic_pkg::CFG_IV_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg  <= s_tuser;
            in_act_reg <= s_tdata;
        end
    end

    aic_datapath #(
        .INTERVAL_BITS (INTERVAL_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .op             (in_op_reg),
        .activity       (in_act_reg),
        .cfg            (cfg_reg),
        .interval       (interval_reg),
        .records        (records_reg),
        .speedups       (speedups_reg),
        .slowdowns      (slowdowns_reg),
        .interval_next  (interval_next),
        .flags          (flags_next),
        .records_next   (records_next),
        .speedups_next  (speedups_next),
        .slowdowns_next (slowdowns_next)
    );

    // The state registers double as the counter and interval fields of the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_BITS'(aic_pkg::START_INTERVAL_RST);
            records_reg   <= '0;
            speedups_reg  <= '0;
            slowdowns_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                interval_reg  <= interval_next;
                records_reg   <= records_next;
                speedups_reg  <= speedups_next;
                slowdowns_reg <= slowdowns_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_flags_reg <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({slowdowns_reg, speedups_reg, records_reg,
                              out_flags_reg.at_max, out_flags_reg.at_min,
                              out_flags_reg.changed, interval_reg});

    `AIC_CHECK(a_counts_bounded, clk, rst_n,
        (records_reg >= speedups_reg) && (records_reg >= slowdowns_reg),
        "speedup or slowdown count exceeds record count")

    `AIC_CHECK_NEXT(a_records_monotonic, clk, rst_n, 1'b1,
        records_reg >= $past(records_reg),
        "record count decreased")

    `AIC_CHECK_NEXT(a_restart_unchanged, clk, rst_n,
        advance && (in_op_reg == aic_pkg::OP_RESTART),
        !out_flags_reg.changed && (records_reg == $past(records_reg)),
        "restart reported a change or counted a record")

    `AIC_CHECK_NEXT(a_stall_holds_state, clk, rst_n,
        out_valid_reg && !m_tready,
        $stable(interval_reg) && out_valid_reg,
        "state moved while a result was stalled")

endmodule
